// ===== hw/rtl/bdcm_pkg.sv =====
// ----------------------------------------------------------------------------
// bdcm_pkg
// shared types, codes and widths of the bitmap disc collision map core
// ----------------------------------------------------------------------------
`default_nettype none

package bdcm_pkg;

    // default map geometry and radius bound
    localparam int DEF_MAP_WIDTH  = 1024;
    localparam int DEF_MAP_HEIGHT = 512;
    localparam int DEF_MAX_RADIUS = 63;

    // fixed field widths
    localparam int POS_W = 12;              // signed pixel coordinate on the ports
    localparam int RAD_W = 6;               // radius field
    localparam int DW    = RAD_W + 1;       // signed disc offset, -63..63
    localparam int CW    = 14;              // signed map coordinate incl. offset
    localparam int SQ_W  = 14;              // dx*dx + dy*dy
    localparam int LHS_W = 16;              // 5 * (dx*dx + dy*dy)

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_TEST  = 2'd1,
        MODE_CARVE = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'd0,
        ST_IDLE  = 3'd1,
        ST_SCAN  = 3'd2,
        ST_DRAIN = 3'd3,
        ST_RESP  = 3'd4
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture a new item
        logic clr_en;     // write one zero of the clearing pass
        logic scan_en;    // issue the current disc offset and step
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;   // clearing pass at its last address
        logic scan_last;  // current offset is the last of the disc
        logic pipe_busy;  // pixel pipeline still holds work
    } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bdcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdcm_ctrl
// sequencer: clearing pass, item load, disc scan, drain and result strobe
// ----------------------------------------------------------------------------
`default_nettype none

module bdcm_ctrl
    import bdcm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] mode,
    input  wire sts_t       sts,
    output cmd_t            cmd,
    output logic            busy,
    output logic            done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        busy        = 1'b1;
        done        = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (mode_t'(mode) == MODE_NONE)
                        state_next = ST_RESP;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (sts.scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                    state_next = ST_RESP;
            end
            ST_RESP:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // an accepted item always keeps the block busy on the next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("bdcm_ctrl: idle after accepted item");

    // the result strobe is followed by an idle cycle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("bdcm_ctrl: not idle after result");

    // the clearing pass runs only once after reset
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLEAR) |=> (state_reg != ST_CLEAR))
        else $error("bdcm_ctrl: clearing pass restarted");

    // the result is never strobed while the pixel pipeline still holds work
    a_resp_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !sts.pipe_busy)
        else $error("bdcm_ctrl: result while pipeline busy");

endmodule

`default_nettype wire

// ===== hw/rtl/bdcm_datapath.sv =====
// ----------------------------------------------------------------------------
// bdcm_datapath
// item registers, disc offset walk, pixel pipeline and occupancy memory
// ----------------------------------------------------------------------------
`default_nettype none

module bdcm_datapath
    import bdcm_pkg::*;
#(
    parameter int MAP_WIDTH  = DEF_MAP_WIDTH,
    parameter int MAP_HEIGHT = DEF_MAP_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cmd_t                    cmd,
    input  wire logic [1:0]              mode,
    input  wire logic signed [POS_W-1:0] pos_x,
    input  wire logic signed [POS_W-1:0] pos_y,
    input  wire logic [RAD_W-1:0]        radius,
    input  wire logic                    pixel_value,
    output sts_t                         sts,
    output logic                         hit
);

    localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    // item registers
    mode_t                  mode_reg;
    logic                   val_reg;
    logic signed [CW-1:0]   cx_reg;
    logic signed [CW-1:0]   cy_reg;
    logic [RAD_W-1:0]       r_reg;
    logic [LHS_W-1:0]       rhs_reg;
    logic signed [DW-1:0]   dx_reg;
    logic signed [DW-1:0]   dy_reg;

    // pipeline
    logic                   a_valid_reg;
    logic signed [CW-1:0]   a_px_reg;
    logic signed [CW-1:0]   a_py_reg;
    logic [SQ_W-1:0]        a_sq_reg;
    logic                   b_valid_reg;
    logic [AW-1:0]          b_addr_reg;
    logic                   c_valid_reg;
    logic                   rd_reg;
    logic                   hit_reg;
    logic [AW-1:0]          clr_cnt_reg;

    logic                   mem_q [0:DEPTH-1];

    // load-time values
    mode_t                  mode_in;
    logic [RAD_W-1:0]       r_sat;
    logic [RAD_W-1:0]       r_load;
    logic [LHS_W-1:0]       r_sq;
    logic [LHS_W-1:0]       rhs_load;
    logic signed [CW-1:0]   pos_x_ext;
    logic signed [CW-1:0]   pos_y_ext;
    logic [CW-1:0]          r_ext;

    assign mode_in   = mode_t'(mode);
    assign r_sat     = (radius > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius;
    assign r_load    = (mode_in == MODE_WRITE) ? '0 : r_sat;
    assign r_sq      = LHS_W'(r_load) * LHS_W'(r_load);
    assign rhs_load  = LHS_W'({r_sq, 2'b00}) + r_sq + LHS_W'({r_load, 2'b00});
    assign pos_x_ext = {{(CW-POS_W){pos_x[POS_W-1]}}, pos_x};
    assign pos_y_ext = {{(CW-POS_W){pos_y[POS_W-1]}}, pos_y};
    assign r_ext     = {{(CW-RAD_W){1'b0}}, r_load};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode_in;
            val_reg  <= pixel_value;
            r_reg    <= r_load;
            rhs_reg  <= rhs_load;
            if (mode_in == MODE_TEST)
            begin
                cx_reg <= pos_x_ext + $signed(r_ext);
                cy_reg <= pos_y_ext + $signed(r_ext);
            end
            else
            begin
                cx_reg <= pos_x_ext;
                cy_reg <= pos_y_ext;
            end
        end
    end

    // offset walk, row by row
    logic                   dx_end;
    logic                   dy_end;

    assign dx_end = (dx_reg == DW'(r_reg));
    assign dy_end = (dy_reg == DW'(r_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dx_reg <= DW'(0) - DW'(r_load);
            dy_reg <= DW'(0) - DW'(r_load);
        end
        else if (cmd.scan_en)
        begin
            if (dx_end)
            begin
                dx_reg <= DW'(0) - DW'(r_reg);
                dy_reg <= dy_reg + DW'(1);
            end
            else
            begin
                dx_reg <= dx_reg + DW'(1);
            end
        end
    end

    // stage a: pixel coordinate and squared distance
    logic signed [SQ_W-1:0] dx_sq;
    logic signed [SQ_W-1:0] dy_sq;

    assign dx_sq = SQ_W'(dx_reg) * SQ_W'(dx_reg);
    assign dy_sq = SQ_W'(dy_reg) * SQ_W'(dy_reg);

    always_ff @(posedge clk)
    begin
        a_px_reg <= cx_reg + {{(CW-DW){dx_reg[DW-1]}}, dx_reg};
        a_py_reg <= cy_reg + {{(CW-DW){dy_reg[DW-1]}}, dy_reg};
        a_sq_reg <= $unsigned(dx_sq) + $unsigned(dy_sq);
    end

    // stage b: disc membership, map bounds and address
    logic                   on_map;
    logic                   in_disc;
    logic [LHS_W-1:0]       lhs;
    logic [AW-1:0]          addr_b;

    assign on_map  = !a_px_reg[CW-1] && !a_py_reg[CW-1]
                  && ($unsigned(a_px_reg) < CW'(MAP_WIDTH))
                  && ($unsigned(a_py_reg) < CW'(MAP_HEIGHT));
    assign lhs     = LHS_W'({a_sq_reg, 2'b00}) + LHS_W'(a_sq_reg);
    assign in_disc = (lhs <= rhs_reg);
    assign addr_b  = AW'($unsigned(a_py_reg)) * AW'(MAP_WIDTH) + AW'($unsigned(a_px_reg));

    always_ff @(posedge clk)
    begin
        b_addr_reg <= addr_b;
    end

    // stage c: memory access; clearing pass shares the write port
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic                   mem_wdata;

    assign mem_we    = cmd.clr_en || (b_valid_reg && (mode_reg != MODE_TEST));
    assign mem_waddr = cmd.clr_en ? clr_cnt_reg : b_addr_reg;
    assign mem_wdata = !cmd.clr_en && (mode_reg == MODE_WRITE) && val_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem_q[mem_waddr] <= mem_wdata;
        rd_reg <= mem_q[b_addr_reg];
    end

    // control registers of the pipeline and the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            hit_reg     <= 1'b0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            a_valid_reg <= cmd.scan_en;
            b_valid_reg <= a_valid_reg && on_map && in_disc;
            c_valid_reg <= b_valid_reg && (mode_reg == MODE_TEST);
            if (cmd.load)
                hit_reg <= 1'b0;
            else if (c_valid_reg && rd_reg)
                hit_reg <= 1'b1;
            if (cmd.clr_en)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    assign sts.clr_last  = (clr_cnt_reg == AW'(DEPTH - 1));
    assign sts.scan_last = dx_end && dy_end;
    assign sts.pipe_busy = a_valid_reg || b_valid_reg || c_valid_reg;
    assign hit           = hit_reg;

    // clearing and scanning never share the write port
    a_clr_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clr_en && (cmd.scan_en || b_valid_reg)))
        else $error("bdcm_datapath: clear overlaps scan");

    // reads that feed the hit flag only come from test items
    a_read_mode: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> (mode_reg == MODE_TEST))
        else $error("bdcm_datapath: hit read outside test");

    // the flag is only raised by an occupied pixel inside the disc
    a_hit_src: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(hit_reg)) |-> $past(c_valid_reg && rd_reg))
        else $error("bdcm_datapath: hit without occupied pixel");

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_disc_collision_map_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_disc_collision_map_core
// one-bit occupancy map with pixel write, disc collision test and disc carve
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Every item gives one
// result: done is high for exactly one cycle with hit valid, and the receiver
// cannot hold it off, so it must take it in that cycle. After reset the block
// sweeps the map to free, one pixel a cycle, with busy high. A test or carve
// item walks the bounding square of its disc one pixel a cycle through the
// occupancy memory, which has one write port and one read port, then drains
// the pixel pipeline, strobes done and returns to idle; its radius is clipped
// to MAX_RADIUS. A pixel write is walked as a disc of radius 0, and an item of
// the unused mode 3 goes straight to its result without a walk. hit is 1 only
// for a test item that finds an occupied pixel inside its disc.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_disc_collision_map_core
    import bdcm_pkg::*;
#(
    parameter int MAP_WIDTH  = DEF_MAP_WIDTH,
    parameter int MAP_HEIGHT = DEF_MAP_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // item channel
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              mode,
    input  wire logic signed [POS_W-1:0] pos_x,
    input  wire logic signed [POS_W-1:0] pos_y,
    input  wire logic [RAD_W-1:0]        radius,
    input  wire logic                    pixel_value,
    // result channel, one cycle strobe
    output logic                         done,
    output logic                         hit
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: clearing pass, load, scan, drain, result
    bdcm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // item registers, pixel pipeline and occupancy memory
    bdcm_datapath #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .mode        (mode),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .radius      (radius),
        .pixel_value (pixel_value),
        .sts         (sts),
        .hit         (hit)
    );

endmodule

`default_nettype wire
